[hdl/e2q_pkg.sv]
// ---------------------------------------------------------------------------
// Euler to quaternion package
// Item types, fixed-point constants and the CORDIC arctangent table builder.
// ---------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int OUT_BITS       = 16;
    localparam int CORDIC_STAGES  = 16;

    // Pi in Q60, and its upper and lower halves for the angle scaling.
    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [29:0] PI_HI    = 30'h3243F6A8;
    localparam logic [31:0] PI_LO    = 32'h885A308D;
    // CORDIC gain, 0.6072529350088813 in Q60.
    localparam logic signed [63:0] GAIN_Q60 = 64'sd700114967507363226;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
        logic signed [ANGLE_BITS-1:0] roll_angle;
    } angles_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] q_x;
        logic signed [OUT_BITS-1:0] q_y;
        logic signed [OUT_BITS-1:0] q_z;
        logic signed [OUT_BITS-1:0] q_w;
    } quat_t;

    // Arctangent of 2^-i in Q60: pi/4 for the first stage, otherwise the
    // alternating power series with each term truncated.
    function automatic logic signed [63:0] atan_q60(input int i);
        logic signed [63:0] acc;
        logic [63:0]        term;
        logic               neg;
        acc = '0;
        neg = 1'b0;
        if (i == 0) begin
            acc = $signed(PI_Q60 >> 2);
        end else begin
            for (int p = 1; i * p <= 60; p += 2) begin
                term = (64'd1 << (60 - i * p)) / 64'(p);
                acc  = neg ? acc - $signed(term) : acc + $signed(term);
                neg  = !neg;
            end
        end
        return acc;
    endfunction

endpackage

[hdl/euler_to_quaternion_top.sv]
// ---------------------------------------------------------------------------
// Euler to quaternion converter
// Turns pitch, yaw and roll binary angles into a Q1.15 unit quaternion
// through three pipelined CORDIC units and a pipelined product network.
// ---------------------------------------------------------------------------
// Channel   Handshake               Payload
// angle     angle_valid/angle_stall angle_data (pitch, yaw, roll)
// quat      quat_valid/quat_stall   quat_data (x, y, z, w)
//
// One item is taken per cycle unless the pipeline stalls; it passes through
// three scaling stages, one stage per CORDIC iteration, rounding, two
// product stages and the output register.
// Every stage holds a valid bit; a stage only stalls when it and all stages
// after it hold items and quat_stall is high, so bubbles are squeezed out while the output waits.
// Reset clears the valid bits only.
module euler_to_quaternion_top #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             angle_valid,
    output logic             angle_stall,
    input  e2q_pkg::angles_t angle_data,
    output logic             quat_valid,
    input  logic             quat_stall,
    output e2q_pkg::quat_t   quat_data
);
    import e2q_pkg::*;

    localparam int CS     = CORDIC_STAGES;
    localparam int S_RND  = CS + 3;
    localparam int S_PAIR = CS + 4;
    localparam int S_TRI  = CS + 5;
    localparam int S_OUT  = CS + 6;
    localparam int NS     = CS + 7;
    localparam int FIN_SH = 62 - OUT_BITS;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    // Stage enables: a stage moves when it is empty or the next one moves.
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !quat_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? angle_valid : v_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign angle_stall = !en[0];
    assign quat_valid  = v_reg[NS-1];

    // Stage 0: magnitude and final sign of each half-angle.
    // Pitch and roll are negated, yaw keeps its sign.
    logic [ANGLE_BITS-1:0] ang_in   [3];
    logic [ANGLE_BITS-1:0] mag_reg  [3];
    logic                  neg_reg  [3];

    assign ang_in[0] = angle_data.pitch_angle;
    assign ang_in[1] = angle_data.yaw_angle;
    assign ang_in[2] = angle_data.roll_angle;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int a = 0; a < 3; a++)
            begin
                mag_reg[a] <= ang_in[a][ANGLE_BITS-1] ? (~ang_in[a] + 1'b1) : ang_in[a];
                neg_reg[a] <= (a == 1) ? ang_in[a][ANGLE_BITS-1] : !ang_in[a][ANGLE_BITS-1];
            end
        end
    end

    // Stage 1: the two partial products of magnitude times pi.
    logic [ANGLE_BITS+29:0] phi_reg  [3];
    logic [ANGLE_BITS+31:0] plo_reg  [3];
    logic                   neg1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int a = 0; a < 3; a++)
            begin
                phi_reg[a]  <= mag_reg[a] * PI_HI;
                plo_reg[a]  <= mag_reg[a] * PI_LO;
                neg1_reg[a] <= neg_reg[a];
            end
        end
    end

    // Stage 2: combine the partial products into the Q60 half-angle.
    logic [63:0]        rad      [3];
    logic signed [63:0] zin_reg  [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            rad[a] = (64'(phi_reg[a]) << (32 - ANGLE_BITS))
                   + (64'(plo_reg[a]) >> ANGLE_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int a = 0; a < 3; a++)
            begin
                zin_reg[a] <= neg1_reg[a] ? -$signed(rad[a]) : $signed(rad[a]);
            end
        end
    end

    // CORDIC iterations, one register stage each, three lanes side by side.
    logic signed [63:0] cx_reg [CS][3];
    logic signed [63:0] cy_reg [CS][3];
    logic signed [63:0] cz_reg [CS][3];

    for (genvar k = 0; k < CS; k++)
    begin : g_cordic
        localparam logic signed [63:0] ATAN_K = atan_q60(k);
        logic signed [63:0] xi [3];
        logic signed [63:0] yi [3];
        logic signed [63:0] zi [3];

        always_comb
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (k == 0)
                begin
                    xi[a] = GAIN_Q60;
                    yi[a] = '0;
                    zi[a] = zin_reg[a];
                end
                else
                begin
                    xi[a] = cx_reg[(k == 0) ? 0 : k-1][a];
                    yi[a] = cy_reg[(k == 0) ? 0 : k-1][a];
                    zi[a] = cz_reg[(k == 0) ? 0 : k-1][a];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[3+k])
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (!zi[a][63])
                    begin
                        cx_reg[k][a] <= xi[a] - (yi[a] >>> k);
                        cy_reg[k][a] <= yi[a] + (xi[a] >>> k);
                        cz_reg[k][a] <= zi[a] - ATAN_K;
                    end
                    else
                    begin
                        cx_reg[k][a] <= xi[a] + (yi[a] >>> k);
                        cy_reg[k][a] <= yi[a] - (xi[a] >>> k);
                        cz_reg[k][a] <= zi[a] + ATAN_K;
                    end
                end
            end
        end
    end

    // Round a Q60 value to Q31 and clamp it to plus or minus one.
    function automatic logic signed [32:0] round_q31(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = (v + (64'sd1 <<< 28)) >>> 29;
        if (s > (64'sd1 <<< 31))
            return 33'sd1 <<< 31;
        else if (s < -(64'sd1 <<< 31))
            return -(33'sd1 <<< 31);
        else
            return s[32:0];
    endfunction

    // Rounding stage: cosine and sine of each half-angle.
    logic signed [32:0] cos_reg [3];
    logic signed [32:0] sin_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[S_RND])
        begin
            for (int a = 0; a < 3; a++)
            begin
                cos_reg[a] <= round_q31(cx_reg[CS-1][a]);
                sin_reg[a] <= round_q31(cy_reg[CS-1][a]);
            end
        end
    end

    // Pair products of roll and pitch terms, rounded to Q31.
    function automatic logic signed [32:0] pair_q31(input logic signed [32:0] a,
                                                    input logic signed [32:0] b);
        logic signed [65:0] pr;
        pr = 66'(a) * 66'(b);
        pr = pr + (66'sd1 <<< 30);
        return pr[63:31];
    endfunction

    logic signed [32:0] crsp_reg, srcp_reg, crcp_reg, srsp_reg;
    logic signed [32:0] cyaw_reg, syaw_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_PAIR])
        begin
            crsp_reg <= pair_q31(cos_reg[2], sin_reg[0]);
            srcp_reg <= pair_q31(sin_reg[2], cos_reg[0]);
            crcp_reg <= pair_q31(cos_reg[2], cos_reg[0]);
            srsp_reg <= pair_q31(sin_reg[2], sin_reg[0]);
            cyaw_reg <= cos_reg[1];
            syaw_reg <= sin_reg[1];
        end
    end

    // Triple products in Q61.
    function automatic logic signed [63:0] tri_q61(input logic signed [32:0] ab,
                                                   input logic signed [32:0] c);
        logic signed [65:0] pr;
        pr = 66'(ab) * 66'(c);
        return pr[64:1];
    endfunction

    logic signed [63:0] tri_reg [8];

    always_ff @(posedge clk)
    begin
        if (en[S_TRI])
        begin
            tri_reg[0] <= tri_q61(crsp_reg, cyaw_reg);
            tri_reg[1] <= tri_q61(srcp_reg, syaw_reg);
            tri_reg[2] <= tri_q61(crcp_reg, syaw_reg);
            tri_reg[3] <= tri_q61(srsp_reg, cyaw_reg);
            tri_reg[4] <= tri_q61(srcp_reg, cyaw_reg);
            tri_reg[5] <= tri_q61(crsp_reg, syaw_reg);
            tri_reg[6] <= tri_q61(crcp_reg, cyaw_reg);
            tri_reg[7] <= tri_q61(srsp_reg, syaw_reg);
        end
    end

    // Round a Q61 sum to the output format and saturate.
    function automatic logic signed [OUT_BITS-1:0] finish(input logic signed [64:0] v);
        logic signed [64:0] s;
        s = (v + (65'sd1 <<< (FIN_SH - 1))) >>> FIN_SH;
        if (s > 65'sd0 && s[64:OUT_BITS-1] != '0)
            return {1'b0, {(OUT_BITS-1){1'b1}}};
        else if (s < 65'sd0 && s[64:OUT_BITS-1] != '1)
            return {1'b1, {(OUT_BITS-1){1'b0}}};
        else
            return s[OUT_BITS-1:0];
    endfunction

    // Output register: component sums.
    quat_t quat_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            quat_reg.q_x <= finish(65'(tri_reg[0]) - 65'(tri_reg[1]));
            quat_reg.q_y <= finish(65'(tri_reg[2]) + 65'(tri_reg[3]));
            quat_reg.q_z <= finish(65'(tri_reg[4]) - 65'(tri_reg[5]));
            quat_reg.q_w <= finish(65'(tri_reg[6]) + 65'(tri_reg[7]));
        end
    end

    assign quat_data = quat_reg;

`ifndef SYNTH
    // An empty output stage lets the whole pipeline advance.
    a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NS-1] |-> !angle_stall)
        else $error("input stalled with an empty output stage");

    // An accepted item lands in the first stage.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_valid && !angle_stall) |=> v_reg[0])
        else $error("accepted item lost at the first stage");

    // A full pipeline with a stalled output must refuse new items.
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && quat_stall) |-> angle_stall)
        else $error("item accepted into a full stalled pipeline");
`endif

endmodule
